// ===== rtl/core/i2cs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cs_pkg: shared types for the I2C register transfer sequencer
// Holds the event codes, the request/event item and the action result record.
// ----------------------------------------------------------------------------
package i2cs_pkg;

	// Request and bus event codes
	typedef enum logic [2:0] {
		FN_WRITE_REQ  = 3'd0,
		FN_READ_REQ   = 3'd1,
		FN_START_SENT = 3'd2,
		FN_TX_ADDR_ACK = 3'd3,
		FN_TX_EMPTY   = 3'd4,
		FN_BYTE_DONE  = 3'd5,
		FN_RX_ADDR_ACK = 3'd6,
		FN_BYTE_RECV  = 3'd7
	} func_t;

	// One request or bus event
	typedef struct packed {
		func_t       func;
		logic [7:0]  slave_addr;
		logic [7:0]  reg_addr;
		logic [15:0] length;
		logic [7:0]  data_byte;
	} item_t;

	// Actions for the bus engine from one transaction
	typedef struct packed {
		logic        accepted;
		logic        busy_res;
		logic        send_start;
		logic        send_addr;
		logic [7:0]  addr_byte;
		logic        send_byte;
		logic [7:0]  tx_byte;
		logic        nack_next;
		logic        send_stop;
		logic        store_valid;
		logic [7:0]  rx_byte;
		logic [15:0] buf_index;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/i2cs_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cs_core: transfer state and per-event decision logic
// Keeps the transfer context and turns one item into the engine actions.
// The context updates only when the item moves on to the result register.
// ----------------------------------------------------------------------------
module i2cs_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                advance,
	input  i2cs_pkg::item_t    item,
	output i2cs_pkg::result_t  result
);
	import i2cs_pkg::*;

	logic        active_q, is_read_q, rx_phase_q;
	logic [7:0]  slave_id_q, reg_byte_q;
	logic [15:0] position_q, total_len_q;

	logic        active_d, is_read_d, rx_phase_d;
	logic [7:0]  slave_id_d, reg_byte_d;
	logic [15:0] position_d, total_len_d;

	logic [15:0] last_idx;
	logic [15:0] pos_inc;

	assign last_idx = total_len_q - 16'd1;
	assign pos_inc  = position_q + 16'd1;

	// Decide actions and next context for the current item
	always_comb begin
		result      = '0;
		active_d    = active_q;
		is_read_d   = is_read_q;
		rx_phase_d  = rx_phase_q;
		slave_id_d  = slave_id_q;
		reg_byte_d  = reg_byte_q;
		position_d  = position_q;
		total_len_d = total_len_q;

		if (item.func inside {FN_WRITE_REQ, FN_READ_REQ}) begin
			// take a request only when idle and non-empty
			if (!active_q && item.length != 16'd0) begin
				active_d          = 1'b1;
				is_read_d         = (item.func == FN_READ_REQ);
				rx_phase_d        = 1'b0;
				slave_id_d        = item.slave_addr;
				reg_byte_d        = item.reg_addr;
				position_d        = 16'd0;
				total_len_d       = item.length;
				result.accepted   = 1'b1;
				result.send_start = 1'b1;
			end
		end else if (active_q) begin
			if (item.func == FN_START_SENT) begin
				result.send_addr = 1'b1;
				result.addr_byte = {slave_id_q[7:1], rx_phase_q};
			end else if (!rx_phase_q) begin
				case (item.func)
					FN_TX_ADDR_ACK: begin
						result.send_byte = 1'b1;
						result.tx_byte   = reg_byte_q;
					end
					FN_TX_EMPTY: begin
						if (!is_read_q && position_q < total_len_q) begin
							result.send_byte = 1'b1;
							result.tx_byte   = item.data_byte;
							result.buf_index = position_q;
							position_d       = pos_inc;
						end
					end
					FN_BYTE_DONE: begin
						if (is_read_q) begin
							// turn around with a repeated start
							rx_phase_d        = 1'b1;
							result.send_start = 1'b1;
						end else begin
							result.nack_next = 1'b1;
							result.send_stop = 1'b1;
							active_d         = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end else begin
				case (item.func)
					FN_RX_ADDR_ACK: begin
						// single-byte read: NACK at once
						if (position_q == last_idx) begin
							result.nack_next = 1'b1;
							result.send_stop = 1'b1;
						end
					end
					FN_BYTE_RECV: begin
						result.store_valid = 1'b1;
						result.rx_byte     = item.data_byte;
						result.buf_index   = position_q;
						position_d         = pos_inc;
						if (pos_inc == last_idx) begin
							result.nack_next = 1'b1;
							result.send_stop = 1'b1;
						end else if (pos_inc >= total_len_q) begin
							rx_phase_d = 1'b0;
							active_d   = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end

		result.busy_res = active_d;
	end

	// Hold the transfer context, advance it with each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			is_read_q   <= 1'b0;
			rx_phase_q  <= 1'b0;
			slave_id_q  <= '0;
			reg_byte_q  <= '0;
			position_q  <= '0;
			total_len_q <= '0;
		end else if (advance) begin
			active_q    <= active_d;
			is_read_q   <= is_read_d;
			rx_phase_q  <= rx_phase_d;
			slave_id_q  <= slave_id_d;
			reg_byte_q  <= reg_byte_d;
			position_q  <= position_d;
			total_len_q <= total_len_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/i2c_master_register_transfer_sequencer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_sequencer_unit: I2C register transfer sequencer
// Sequences register-addressed master writes and reads over a byte engine.
// ----------------------------------------------------------------------------
// Each request or bus event yields exactly one result: the accepting edge loads the
// input register, and the result register loads from it once no stalled result
// holds it. One transaction is taken per clock; the throughput is set only by
// the result register draining, so a stalled result blocks a new transaction
// only once the input register is also full.
module i2c_master_register_transfer_sequencer_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         req_valid,
	output logic        req_stall,
	input  wire  [2:0]  func,
	input  wire  [7:0]  slave_addr,
	input  wire  [7:0]  reg_addr,
	input  wire  [15:0] length,
	input  wire  [7:0]  data_byte,
	output logic        res_valid,
	input  wire         res_stall,
	output logic        accepted,
	output logic        busy_res,
	output logic        send_start,
	output logic        send_addr,
	output logic [7:0]  addr_byte,
	output logic        send_byte,
	output logic [7:0]  tx_byte,
	output logic        nack_next,
	output logic        send_stop,
	output logic        store_valid,
	output logic [7:0]  rx_byte,
	output logic [15:0] buf_index
);
	import i2cs_pkg::*;

	logic    valid_s1, valid_s2;
	item_t   item_s1;
	result_t res_s2, res_next;
	logic    s2_free, advance;

	assign s2_free   = !valid_s2 || !res_stall;
	assign advance   = valid_s1 && s2_free;
	assign req_stall = valid_s1 && !s2_free;

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= '{func: func_t'(func), slave_addr: slave_addr,
				reg_addr: reg_addr, length: length, data_byte: data_byte};
		end
	end

	i2cs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (res_next)
	);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid   = valid_s2;
	assign accepted    = res_s2.accepted;
	assign busy_res    = res_s2.busy_res;
	assign send_start  = res_s2.send_start;
	assign send_addr   = res_s2.send_addr;
	assign addr_byte   = res_s2.addr_byte;
	assign send_byte   = res_s2.send_byte;
	assign tx_byte     = res_s2.tx_byte;
	assign nack_next   = res_s2.nack_next;
	assign send_stop   = res_s2.send_stop;
	assign store_valid = res_s2.store_valid;
	assign rx_byte     = res_s2.rx_byte;
	assign buf_index   = res_s2.buf_index;

endmodule
`default_nettype wire

// ===== rtl/core/i2cs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cs_checker: port-level checks for the I2C register transfer sequencer
// Watches the result channel for action combinations the sequencer never makes.
// ----------------------------------------------------------------------------
module i2cs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        res_valid,
	input wire        res_stall,
	input wire        accepted,
	input wire        busy_res,
	input wire        send_start,
	input wire        send_addr,
	input wire        send_byte,
	input wire        nack_next,
	input wire        send_stop,
	input wire        store_valid
);

	// A taken request always opens with a start and leaves the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && accepted |-> send_start && busy_res)
		else $error("accepted request without start or busy");

	// Stop is always paired with NACK
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && send_stop |-> nack_next)
		else $error("stop without nack");

	// At most one bus action per transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $countones({send_addr, send_byte, store_valid, send_start}) <= 1)
		else $error("conflicting engine actions");

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

endmodule

bind i2c_master_register_transfer_sequencer_unit i2cs_checker u_i2cs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.accepted    (accepted),
	.busy_res    (busy_res),
	.send_start  (send_start),
	.send_addr   (send_addr),
	.send_byte   (send_byte),
	.nack_next   (nack_next),
	.send_stop   (send_stop),
	.store_valid (store_valid)
);
`default_nettype wire
